// ===== rtl/aws_pkg.sv =====
// types, constants and sequence helpers for the arq window sender
// used by every module of the block, depends on nothing
package aws_pkg;

  localparam int MaxSeqNum = 7;
  localparam int Slots     = 7;
  localparam int SeqW      = 3;
  localparam int SlotW     = $clog2(Slots);
  localparam int WinW      = 3;
  localparam int TimerW    = 16;
  localparam int MaskW     = 8;
  localparam int CfgW      = 16;
  localparam int CfgIdxW   = 2;
  localparam int ErrW      = 2;
  localparam int ActW      = 3;
  localparam int CntW      = $clog2(Slots + 1);

  localparam logic [WinW-1:0]   WindowRst = WinW'(7);
  localparam logic [TimerW-1:0] ResendRst = TimerW'(10000);

  localparam logic [CfgIdxW-1:0] CFG_WINDOW = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_RESEND = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CFG_LOST   = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CFG_CHKSUM = CfgIdxW'(3);

  localparam logic [ErrW-1:0] ERR_NONE   = ErrW'(0);
  localparam logic [ErrW-1:0] ERR_LOST   = ErrW'(1);
  localparam logic [ErrW-1:0] ERR_CHKSUM = ErrW'(2);

  localparam logic [ActW-1:0] ACT_START = ActW'(0);
  localparam logic [ActW-1:0] ACT_SEND  = ActW'(1);
  localparam logic [ActW-1:0] ACT_TICK  = ActW'(2);
  localparam logic [ActW-1:0] ACT_ACK   = ActW'(3);
  localparam logic [ActW-1:0] ACT_NAK   = ActW'(4);
  localparam logic [ActW-1:0] ACT_STOP  = ActW'(5);

  typedef struct packed {
    logic [ActW-1:0] action;
    logic [SeqW-1:0] ack_num;
    logic            frame_damaged;
  } in_word_t;

  typedef struct packed {
    logic            frame_valid;
    logic [SeqW-1:0] frame_seq;
    logic [ErrW-1:0] frame_err_mode;
    logic            is_resend;
    logic [SeqW-1:0] window_low;
    logic [SeqW-1:0] window_next;
    logic [WinW-1:0] in_flight;
    logic            last;
  } out_word_t;

  typedef struct packed {
    logic [SeqW-1:0] seq;
    logic [ErrW-1:0] err;
    logic            resend;
  } frame_t;

  typedef struct packed {
    logic   valid;
    frame_t frame;
  } push_t;

  typedef struct packed {
    logic            start;
    logic [SeqW-1:0] low;
    logic [SeqW-1:0] next;
    logic [WinW-1:0] flight;
  } fin_t;

  typedef enum logic [2:0] {
    BANK_NOP,
    BANK_CLEAR,
    BANK_LOAD,
    BANK_REARM,
    BANK_DISARM,
    BANK_TICK
  } bank_op_e;

  typedef struct packed {
    bank_op_e          op;
    logic [SlotW-1:0]  slot;
    logic [SeqW-1:0]   seq;
    logic [TimerW-1:0] resend;
  } bank_cmd_t;

  typedef struct packed {
    logic            armed;
    logic            expire;
    logic [SeqW-1:0] seq;
  } bank_stat_t;

  function automatic logic [SeqW-1:0] seq_inc(input logic [SeqW-1:0] s);
    return (s == SeqW'(MaxSeqNum)) ? '0 : s + SeqW'(1);
  endfunction

  function automatic logic [SeqW-1:0] seq_dec(input logic [SeqW-1:0] s);
    return (s == '0) ? SeqW'(MaxSeqNum) : s - SeqW'(1);
  endfunction

  // true when b lies in [a, c) on the sequence circle
  function automatic logic seq_inside(input logic [SeqW-1:0] a,
                                      input logic [SeqW-1:0] b,
                                      input logic [SeqW-1:0] c);
    return (a <= b && b < c) || (c < a && a <= b) || (b < c && c < a);
  endfunction

  // s mod w for narrow values, w at least 1
  function automatic logic [SlotW-1:0] seq_mod(input logic [SeqW-1:0] s,
                                               input logic [WinW-1:0] w);
    logic [SeqW-1:0] r;
    r = s;
    for (int k = 0; k < MaxSeqNum; k++) begin
      if (r >= w) begin
        r = r - w;
      end
    end
    return r[SlotW-1:0];
  endfunction

endpackage

// ===== rtl/aws_slot_bank.sv =====
// per-slot retransmit timers, armed flags and stored sequence numbers
// one shared decrement and compare unit serves the addressed slot; uses aws_pkg
module aws_slot_bank (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  aws_pkg::bank_cmd_t  cmd_i,
  output aws_pkg::bank_stat_t stat_o
);
  import aws_pkg::*;

  logic [TimerW-1:0] timer_q [Slots];
  logic              armed_q [Slots];
  logic [SeqW-1:0]   seq_q   [Slots];

  logic [TimerW-1:0] cur_timer;
  logic [TimerW-1:0] dec_timer;
  logic              cur_armed;

  always_comb begin
    cur_timer = timer_q[cmd_i.slot];
    cur_armed = armed_q[cmd_i.slot];
    dec_timer = (cur_timer == '0) ? '0 : cur_timer - TimerW'(1);
    stat_o.armed  = cur_armed;
    stat_o.seq    = seq_q[cmd_i.slot];
    stat_o.expire = (cmd_i.op == BANK_TICK) && cur_armed && (dec_timer == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Slots; k++) begin
        timer_q[k] <= '0;
        armed_q[k] <= 1'b0;
      end
    end else begin
      case (cmd_i.op)
        BANK_CLEAR: begin
          for (int k = 0; k < Slots; k++) begin
            timer_q[k] <= '0;
            armed_q[k] <= 1'b0;
          end
        end
        BANK_LOAD, BANK_REARM: begin
          timer_q[cmd_i.slot] <= cmd_i.resend;
          armed_q[cmd_i.slot] <= 1'b1;
        end
        BANK_DISARM: begin
          timer_q[cmd_i.slot] <= '0;
          armed_q[cmd_i.slot] <= 1'b0;
        end
        BANK_TICK: begin
          if (cur_armed) begin
            timer_q[cmd_i.slot] <= (dec_timer == '0) ? cmd_i.resend : dec_timer;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == BANK_LOAD) begin
      seq_q[cmd_i.slot] <= cmd_i.seq;
    end
  end

endmodule

// ===== rtl/aws_out_queue.sv =====
// collects the frames of one input item and hands them out as result words
// output register with the final window fields; uses aws_pkg
module aws_out_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  aws_pkg::push_t     push_i,
  input  aws_pkg::fin_t      fin_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output aws_pkg::out_word_t out_word_o,
  output logic               busy_o
);
  import aws_pkg::*;

  frame_t          entry_q [Slots];
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] rd_q;
  logic            valid_q;
  out_word_t       word_q;
  frame_t          rd_frame;

  assign rd_frame    = entry_q[rd_q[SlotW-1:0]];
  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;
  assign busy_o      = valid_q;

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      entry_q[cnt_q[SlotW-1:0]] <= push_i.frame;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      rd_q    <= '0;
      valid_q <= 1'b0;
      word_q  <= '0;
    end else begin
      if (push_i.valid) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (fin_i.start) begin
        valid_q            <= 1'b1;
        word_q.window_low  <= fin_i.low;
        word_q.window_next <= fin_i.next;
        word_q.in_flight   <= fin_i.flight;
        if (cnt_q == '0) begin
          word_q.frame_valid    <= 1'b0;
          word_q.frame_seq      <= '0;
          word_q.frame_err_mode <= ERR_NONE;
          word_q.is_resend      <= 1'b0;
          word_q.last           <= 1'b1;
        end else begin
          word_q.frame_valid    <= 1'b1;
          word_q.frame_seq      <= rd_frame.seq;
          word_q.frame_err_mode <= rd_frame.err;
          word_q.is_resend      <= rd_frame.resend;
          word_q.last           <= (cnt_q == CntW'(1));
          rd_q                  <= rd_q + CntW'(1);
        end
      end else if (valid_q && !out_stall_i) begin
        if (word_q.last) begin
          valid_q <= 1'b0;
          cnt_q   <= '0;
          rd_q    <= '0;
        end else begin
          word_q.frame_seq      <= rd_frame.seq;
          word_q.frame_err_mode <= rd_frame.err;
          word_q.is_resend      <= rd_frame.resend;
          word_q.last           <= (rd_q + CntW'(1) == cnt_q);
          rd_q                  <= rd_q + CntW'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/arq_window_sender.sv =====
// arq window sender: the sequencer and state registers of the block
// uses aws_pkg, aws_slot_bank and aws_out_queue
//
//   input words carry an action (start, send, tick, ack, nak, stop), an ack
//   number and a damaged flag; each one yields one to seven result words,
//   the final one marked last, all carrying the window edges and the
//   in-flight count as they stand after the whole action
//   configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i and
//   sampled into working copies by a start action
//   in_stall_o is high from the accepted word until its last result word
//   has been taken; one word is processed at a time
//   each word runs its slot walk, then a finish state that starts the
//   result words and a drain state that waits until all are taken; a
//   send loads one slot, a tick visits each window slot in turn, an ack
//   disarms the slot of each acknowledged frame and a nak first rearms
//   the named frame's slot, then walks as an ack; all timer work goes
//   through one shared decrement and compare unit; a stall on the output
//   holds the current result word and stalls the input; nothing is lost
//   reset: not running, edges and count zero, timers disarmed,
//   configuration at window 7, timeout 10000 ticks, masks clear
module arq_window_sender (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  aws_pkg::in_word_t              in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output aws_pkg::out_word_t             out_word_o,
  input  logic                           cfg_we_i,
  input  logic [aws_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [aws_pkg::CfgW-1:0]       cfg_data_i
);
  import aws_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEND,
    S_TICK,
    S_NAK,
    S_ACK,
    S_FINISH,
    S_DRAIN
  } state_e;

  state_e            state_q;
  in_word_t          item_q;
  logic              running_q;
  logic [SeqW-1:0]   lower_q;
  logic [SeqW-1:0]   upper_q;
  logic [WinW-1:0]   flight_q;
  logic [SeqW-1:0]   acked_q;
  logic [SlotW-1:0]  tick_q;

  logic [WinW-1:0]   cfg_win_q;
  logic [TimerW-1:0] cfg_resend_q;
  logic [MaskW-1:0]  cfg_lost_q;
  logic [MaskW-1:0]  cfg_chk_q;
  logic [WinW-1:0]   use_win_q;
  logic [TimerW-1:0] use_resend_q;
  logic [MaskW-1:0]  use_lost_q;
  logic [MaskW-1:0]  use_chk_q;

  logic              in_accept;
  logic [SeqW-1:0]   mod_arg;
  logic [SlotW-1:0]  mod_slot;
  logic              nak_hit;
  logic              ack_hit;
  logic [ErrW-1:0]   send_err;
  logic [WinW-1:0]   start_win;
  bank_cmd_t         bank_cmd;
  bank_stat_t        bank_stat;
  push_t             push;
  fin_t              fin;
  logic              q_busy;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    start_win = (cfg_win_q == '0) ? WinW'(1) : cfg_win_q;
    if (start_win > WinW'(MaxSeqNum)) begin
      start_win = WinW'(MaxSeqNum);
    end
    if (start_win > WinW'(Slots)) begin
      start_win = WinW'(Slots);
    end
  end

  always_comb begin
    case (state_q)
      S_SEND:  mod_arg = upper_q;
      S_NAK:   mod_arg = item_q.ack_num;
      default: mod_arg = lower_q;
    endcase
  end

  assign mod_slot = seq_mod(mod_arg, use_win_q);
  assign nak_hit  = seq_inside(lower_q, item_q.ack_num, upper_q);
  assign ack_hit  = seq_inside(lower_q, acked_q, upper_q);

  always_comb begin
    if (use_chk_q[upper_q]) begin
      send_err = ERR_CHKSUM;
    end else if (use_lost_q[upper_q]) begin
      send_err = ERR_LOST;
    end else begin
      send_err = ERR_NONE;
    end
  end

  always_comb begin
    bank_cmd.op     = BANK_NOP;
    bank_cmd.slot   = mod_slot;
    bank_cmd.seq    = upper_q;
    bank_cmd.resend = use_resend_q;
    push.valid      = 1'b0;
    push.frame.seq    = bank_stat.seq;
    push.frame.err    = ERR_NONE;
    push.frame.resend = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_accept && (in_word_i.action == ACT_START ||
                          in_word_i.action == ACT_STOP)) begin
          bank_cmd.op = BANK_CLEAR;
        end
      end
      S_SEND: begin
        bank_cmd.op       = BANK_LOAD;
        push.valid        = 1'b1;
        push.frame.seq    = upper_q;
        push.frame.err    = send_err;
        push.frame.resend = 1'b0;
      end
      S_TICK: begin
        bank_cmd.op   = BANK_TICK;
        bank_cmd.slot = tick_q;
        push.valid    = bank_stat.expire;
      end
      S_NAK: begin
        if (nak_hit) begin
          bank_cmd.op = BANK_REARM;
          push.valid  = 1'b1;
        end
      end
      S_ACK: begin
        if (ack_hit) begin
          bank_cmd.op = BANK_DISARM;
        end
      end
      default: begin
      end
    endcase
  end

  assign fin.start  = (state_q == S_FINISH);
  assign fin.low    = lower_q;
  assign fin.next   = upper_q;
  assign fin.flight = flight_q;

  aws_slot_bank u_bank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (bank_cmd),
    .stat_o (bank_stat)
  );

  aws_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .fin_i       (fin),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .busy_o      (q_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_win_q    <= WindowRst;
      cfg_resend_q <= ResendRst;
      cfg_lost_q   <= '0;
      cfg_chk_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WINDOW: cfg_win_q    <= cfg_data_i[WinW-1:0];
        CFG_RESEND: cfg_resend_q <= cfg_data_i[TimerW-1:0];
        CFG_LOST:   cfg_lost_q   <= cfg_data_i[MaskW-1:0];
        CFG_CHKSUM: cfg_chk_q    <= cfg_data_i[MaskW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      item_q       <= '0;
      running_q    <= 1'b0;
      lower_q      <= '0;
      upper_q      <= '0;
      flight_q     <= '0;
      acked_q      <= '0;
      tick_q       <= '0;
      use_win_q    <= WindowRst;
      use_resend_q <= ResendRst;
      use_lost_q   <= '0;
      use_chk_q    <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            item_q  <= in_word_i;
            acked_q <= in_word_i.ack_num;
            tick_q  <= '0;
            state_q <= S_FINISH;
            if (in_word_i.action == ACT_START) begin
              use_win_q    <= start_win;
              use_resend_q <= (cfg_resend_q == '0) ? TimerW'(1) : cfg_resend_q;
              use_lost_q   <= cfg_lost_q;
              use_chk_q    <= cfg_chk_q;
              lower_q      <= '0;
              upper_q      <= '0;
              flight_q     <= '0;
              running_q    <= 1'b1;
            end else if (in_word_i.action == ACT_STOP) begin
              running_q <= 1'b0;
            end else if (running_q) begin
              if (in_word_i.action == ACT_SEND && flight_q < use_win_q) begin
                state_q <= S_SEND;
              end else if (in_word_i.action == ACT_TICK) begin
                state_q <= S_TICK;
              end else if (in_word_i.action == ACT_ACK && !in_word_i.frame_damaged) begin
                state_q <= S_ACK;
              end else if (in_word_i.action == ACT_NAK && !in_word_i.frame_damaged) begin
                state_q <= S_NAK;
              end
            end
          end
        end
        S_SEND: begin
          flight_q <= flight_q + WinW'(1);
          upper_q  <= seq_inc(upper_q);
          state_q  <= S_FINISH;
        end
        S_TICK: begin
          tick_q <= tick_q + SlotW'(1);
          if (WinW'(tick_q) + WinW'(1) >= use_win_q) begin
            state_q <= S_FINISH;
          end
        end
        S_NAK: begin
          acked_q <= seq_dec(item_q.ack_num);
          state_q <= S_ACK;
        end
        S_ACK: begin
          if (ack_hit) begin
            if (flight_q != '0) begin
              flight_q <= flight_q - WinW'(1);
            end
            lower_q <= seq_inc(lower_q);
          end else begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          state_q <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!q_busy) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_idle_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("result word pending while input is open");

  a_flight_in_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> (flight_q <= use_win_q))
    else $error("in-flight count above window");

  a_last_ends_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_word_o.last) |=> !out_valid_o)
    else $error("result word after last");
`endif

endmodule

// ===== tb/sv/arq_window_sender_tb.sv =====
// self-checking testbench for arq_window_sender: directed and random link events,
// each checked against a built-in prediction of the window and timer state
// depends on aws_pkg and the arq_window_sender rtl
`timescale 1ns / 100ps

module arq_window_sender_tb;
  import aws_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int PhaseWords = 36;
  localparam int RandPhases = 7;
  localparam logic [ActW-1:0] ACT_SPARE = ActW'(7);

  logic                 clk      = 1'b0;
  logic                 rst_n    = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_word  = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_word;
  logic                 cfg_we   = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx  = CFG_WINDOW;
  logic [CfgW-1:0]      cfg_data = '0;

  int unsigned cycle_cnt  = 0;
  int unsigned mismatches = 0;

  in_word_t  link_events [$];
  out_word_t words_due [$];
  out_word_t wanted_word;
  frame_t    step_frames [$];

  // predicted block state
  logic              reg_running = 1'b0;
  logic [SeqW-1:0]   low_edge    = '0;
  logic [SeqW-1:0]   next_edge   = '0;
  logic [WinW-1:0]   flight      = '0;
  logic [TimerW-1:0] slot_countdown [Slots] = '{default: '0};
  logic              slot_live      [Slots] = '{default: 1'b0};
  logic [SeqW-1:0]   slot_seq_no    [Slots] = '{default: '0};
  logic [WinW-1:0]   reg_window  = WindowRst;
  logic [TimerW-1:0] reg_timeout = ResendRst;
  logic [MaskW-1:0]  reg_lost    = '0;
  logic [MaskW-1:0]  reg_chk     = '0;
  logic [WinW-1:0]   cur_window  = WindowRst;
  logic [TimerW-1:0] cur_timeout = ResendRst;
  logic [MaskW-1:0]  cur_lost    = '0;
  logic [MaskW-1:0]  cur_chk     = '0;

  arq_window_sender u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [SeqW-1:0] seq_after(input logic [SeqW-1:0] s);
    return SeqW'((int'(s) + 1) % (MaxSeqNum + 1));
  endfunction

  // b on the arc [a, c) of the sequence circle
  function automatic logic on_arc(input logic [SeqW-1:0] a, input logic [SeqW-1:0] b,
                                  input logic [SeqW-1:0] c);
    return (a <= b && b < c) || (c < a && a <= b) || (b < c && c < a);
  endfunction

  function automatic logic take_break();
    if ((cycle_cnt % 4000) >= 2800) begin
      return 1'b0;
    end
    return $urandom_range(0, 99) < 38;
  endfunction

  function automatic string word_text(input out_word_t w);
    return $sformatf("fv=%0d seq=%0d err=%0d re=%0d low=%0d next=%0d flight=%0d last=%0d",
                     w.frame_valid, w.frame_seq, w.frame_err_mode, w.is_resend,
                     w.window_low, w.window_next, w.in_flight, w.last);
  endfunction

  task automatic clear_timers();
    for (int i = 0; i < Slots; i++) begin
      slot_countdown[i] = '0;
      slot_live[i] = 1'b0;
    end
  endtask

  task automatic resend_slot_frame(input int slot);
    frame_t f;
    if (step_frames.size() < Slots) begin
      slot_countdown[slot] = cur_timeout;
      slot_live[slot] = 1'b1;
      f.seq = slot_seq_no[slot];
      f.err = ERR_NONE;
      f.resend = 1'b1;
      step_frames.push_back(f);
    end
  endtask

  // applies one accepted word and queues the result words it must produce
  task automatic advance_window(input in_word_t w);
    frame_t          f;
    out_word_t       o;
    logic [SeqW-1:0] acked;
    int              slot;
    int              n;
    step_frames.delete();
    case (w.action)
      ACT_START: begin
        cur_window  = (reg_window == '0) ? WinW'(1) : reg_window;
        cur_timeout = (reg_timeout == '0) ? TimerW'(1) : reg_timeout;
        cur_lost    = reg_lost;
        cur_chk     = reg_chk;
        low_edge    = '0;
        next_edge   = '0;
        flight      = '0;
        clear_timers();
        reg_running = 1'b1;
      end
      ACT_STOP: begin
        clear_timers();
        reg_running = 1'b0;
      end
      ACT_SEND: begin
        if (reg_running && flight < cur_window) begin
          slot = int'(next_edge) % int'(cur_window);
          f.seq = next_edge;
          f.err = cur_chk[next_edge] ? ERR_CHKSUM : (cur_lost[next_edge] ? ERR_LOST : ERR_NONE);
          f.resend = 1'b0;
          flight = flight + 1'b1;
          slot_seq_no[slot] = next_edge;
          slot_countdown[slot] = cur_timeout;
          slot_live[slot] = 1'b1;
          step_frames.push_back(f);
          next_edge = seq_after(next_edge);
        end
      end
      ACT_TICK: begin
        if (reg_running) begin
          for (int i = 0; i < int'(cur_window); i++) begin
            if (slot_live[i]) begin
              if (slot_countdown[i] != '0) begin
                slot_countdown[i] = slot_countdown[i] - 1'b1;
              end
              if (slot_countdown[i] == '0) begin
                resend_slot_frame(i);
              end
            end
          end
        end
      end
      ACT_ACK, ACT_NAK: begin
        if (reg_running && !w.frame_damaged) begin
          acked = w.ack_num;
          if (w.action == ACT_NAK) begin
            if (on_arc(low_edge, w.ack_num, next_edge)) begin
              resend_slot_frame(int'(w.ack_num) % int'(cur_window));
            end
            acked = SeqW'((int'(w.ack_num) + MaxSeqNum) % (MaxSeqNum + 1));
          end
          while (on_arc(low_edge, acked, next_edge)) begin
            slot = int'(low_edge) % int'(cur_window);
            if (flight != '0) begin
              flight = flight - 1'b1;
            end
            slot_live[slot] = 1'b0;
            slot_countdown[slot] = '0;
            low_edge = seq_after(low_edge);
          end
        end
      end
      default: begin
      end
    endcase

    n = (step_frames.size() == 0) ? 1 : step_frames.size();
    for (int i = 0; i < n; i++) begin
      o = '0;
      if (step_frames.size() != 0) begin
        o.frame_valid    = 1'b1;
        o.frame_seq      = step_frames[i].seq;
        o.frame_err_mode = step_frames[i].err;
        o.is_resend      = step_frames[i].resend;
      end
      o.window_low  = low_edge;
      o.window_next = next_edge;
      o.in_flight   = flight;
      o.last        = (i == n - 1);
      words_due.push_back(o);
    end
  endtask

  // mostly protocol-shaped events aimed at the live window, some noise
  function automatic in_word_t next_event();
    in_word_t w;
    int       pick;
    pick = $urandom_range(0, 99);
    w.action = ACT_TICK;
    w.ack_num = SeqW'($urandom_range(0, MaxSeqNum));
    w.frame_damaged = 1'b0;
    if (!reg_running && pick < 60) begin
      w.action = ACT_START;
    end else if (pick < 36) begin
      w.action = ACT_SEND;
    end else if (pick < 60) begin
      w.action = ACT_TICK;
    end else if (pick < 90) begin
      w.action = (pick < 78) ? ACT_ACK : ACT_NAK;
      if ($urandom_range(0, 3) != 0) begin
        w.ack_num = SeqW'((int'(low_edge) + $urandom_range(0, int'(flight))) % (MaxSeqNum + 1));
      end
      w.frame_damaged = ($urandom_range(0, 9) == 0);
    end else if (pick < 93) begin
      w.action = ACT_STOP;
    end else if (pick < 95) begin
      w.action = ACT_START;
    end else begin
      w.action = ActW'($urandom_range(0, 7));
      w.frame_damaged = 1'($urandom_range(0, 1));
    end
    return w;
  endfunction

  task automatic queue_word(input logic [ActW-1:0] act, input logic [SeqW-1:0] num,
                            input logic dmg);
    in_word_t w;
    w.action = act;
    w.ack_num = num;
    w.frame_damaged = dmg;
    link_events.push_back(w);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      CFG_WINDOW: reg_window  = data[WinW-1:0];
      CFG_RESEND: reg_timeout = data[TimerW-1:0];
      CFG_LOST:   reg_lost    = data[MaskW-1:0];
      CFG_CHKSUM: reg_chk     = data[MaskW-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic set_config(input logic [WinW-1:0] win, input logic [TimerW-1:0] tmo,
                            input logic [MaskW-1:0] lost_bits,
                            input logic [MaskW-1:0] chk_bits);
    write_cfg(CFG_WINDOW, CfgW'(win));
    write_cfg(CFG_RESEND, CfgW'(tmo));
    write_cfg(CFG_LOST, CfgW'(lost_bits));
    write_cfg(CFG_CHKSUM, CfgW'(chk_bits));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold off until the block has drained everything
  task automatic settle();
    do @(negedge clk);
    while (link_events.size() != 0 || in_valid || words_due.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_window(in_word);
      end
      if (!in_valid || !in_stall) begin
        if (link_events.size() != 0 && !take_break()) begin
          in_valid <= 1'b1;
          in_word  <= link_events.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (words_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result word: %s", word_text(out_word));
          end
        end else begin
          wanted_word = words_due.pop_front();
          if (out_word !== wanted_word) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("word mismatch at cycle %0d", cycle_cnt);
              $display("  expected %s", word_text(wanted_word));
              $display("  actual   %s", word_text(out_word));
            end
          end
        end
      end
      out_stall <= take_break();
    end
  end

  initial begin
    logic [WinW-1:0]   win;
    logic [TimerW-1:0] tmo;
    logic [MaskW-1:0]  lost_bits;
    logic [MaskW-1:0]  chk_bits;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // zero window and zero timeout, checksum mark over lost
    set_config('0, '0, 8'hFF, 8'h0F);
    queue_word(ACT_SEND, '0, 1'b0);
    queue_word(ACT_TICK, '0, 1'b0);
    queue_word(ACT_SPARE, 3'd5, 1'b1);
    queue_word(ACT_START, '0, 1'b0);
    queue_word(ACT_SEND, '0, 1'b0);
    queue_word(ACT_SEND, '0, 1'b0);
    queue_word(ACT_TICK, '0, 1'b0);
    queue_word(ACT_NAK, '0, 1'b1);
    queue_word(ACT_NAK, '0, 1'b0);
    queue_word(ACT_ACK, '0, 1'b0);
    queue_word(ACT_SEND, '0, 1'b0);
    queue_word(ACT_STOP, '0, 1'b0);
    settle();

    // full window, restart, every timer expiring on one tick
    set_config(WinW'(7), TimerW'(2), 8'hF0, 8'h30);
    queue_word(ACT_START, '0, 1'b0);
    queue_word(ACT_SEND, '0, 1'b0);
    queue_word(ACT_START, '0, 1'b0);
    for (int i = 0; i < 8; i++) begin
      queue_word(ACT_SEND, '0, 1'b0);
    end
    queue_word(ACT_TICK, '0, 1'b0);
    queue_word(ACT_TICK, '0, 1'b0);
    queue_word(ACT_NAK, 3'd3, 1'b0);
    queue_word(ACT_ACK, 3'd6, 1'b1);
    queue_word(ACT_ACK, 3'd6, 1'b0);
    settle();

    for (int p = 0; p < RandPhases; p++) begin
      win = (p == 0) ? WinW'(7) : (p == 1) ? WinW'(1) : WinW'($urandom_range(0, 7));
      tmo = (p == 2) ? '1 : TimerW'($urandom_range(1, 5));
      lost_bits = (p == 4) ? '1 : MaskW'($urandom_range(0, 255));
      chk_bits  = (p == 4) ? '1 : (p == 5) ? '0 : MaskW'($urandom_range(0, 255));
      set_config(win, tmo, lost_bits, chk_bits);
      queue_word(ACT_START, '0, 1'b0);
      for (int k = 0; k < PhaseWords; k++) begin
        while (link_events.size() >= 2) @(posedge clk);
        link_events.push_back(next_event());
      end
      settle();
    end

    repeat (16) @(posedge clk);
    if (mismatches == 0 && words_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
